[hdl/lrp_pkg.sv]
// Shared constants, types and command struct for the LRU page replacement block.
package lrp_pkg;

    localparam int MAX_FRAMES  = 8;
    localparam int PAGE_BITS   = 20;
    localparam int FAULT_W     = 32;
    localparam int CFG_W       = 4;
    localparam int FRAME_IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int RANK_W      = FRAME_IDX_W;
    // Wide enough to hold MAX_FRAMES itself (count of frames, or an "older than all" age).
    localparam int COUNT_W     = $clog2(MAX_FRAMES + 1);
    localparam int AGE_W       = (RANK_W + 1 > COUNT_W) ? RANK_W + 1 : COUNT_W;

    localparam logic [CFG_W-1:0]   CFG_RESET  = CFG_W'(4);
    localparam logic [FAULT_W-1:0] FAULT_MAX  = '1;

    typedef logic [PAGE_BITS-1:0]   page_t;
    typedef logic [FRAME_IDX_W-1:0] frame_idx_t;
    typedef logic [RANK_W-1:0]      rank_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;   // latch page and lookup decision
        logic commit;    // apply recency update, tag write, fault count
    } lrp_cmd_t;

endpackage

[hdl/lrp_ctrl.sv]
// Controller state machine: accepts a reference, sequences lookup and update.
module lrp_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output lrp_pkg::lrp_cmd_t cmd
);

    typedef enum logic [1:0]
    {
        ST_IDLE   = 2'b01,
        ST_UPDATE = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.commit;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

[hdl/lrp_datapath.sv]
// Datapath: frame tags, valid bits, recency ranks, lookup/victim logic, fault counter.
module lrp_datapath
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  lrp_pkg::lrp_cmd_t                cmd,
    input  logic                             cfg_wr_en,
    input  logic [lrp_pkg::CFG_W-1:0]        cfg_wr_data,
    input  lrp_pkg::page_t                   page,
    output logic                             hit,
    output lrp_pkg::frame_idx_t              frame_index,
    output logic                             evicted_valid,
    output lrp_pkg::page_t                   evicted_page,
    output logic [lrp_pkg::FAULT_W-1:0]      fault_count
);

    localparam int NF = lrp_pkg::MAX_FRAMES;

    logic [lrp_pkg::CFG_W-1:0]   cfg_reg;
    lrp_pkg::page_t              tag_reg   [NF];
    logic [NF-1:0]               valid_reg;
    lrp_pkg::rank_t              rank_reg  [NF];
    logic [lrp_pkg::FAULT_W-1:0] faults_reg;

    lrp_pkg::page_t              page_reg;
    logic                        hit_reg;
    lrp_pkg::frame_idx_t         target_reg;
    logic                        evict_reg;
    lrp_pkg::page_t              evict_page_reg;

    logic [lrp_pkg::COUNT_W-1:0] eff_cnt;
    logic                        hit_next;
    lrp_pkg::frame_idx_t         target_next;
    logic                        evict_next;
    lrp_pkg::page_t              evict_page_next;

    logic [lrp_pkg::AGE_W-1:0]   old_age;

    // Effective frame count: zero acts as one, above the maximum clamps.
    always_comb
    begin
        if (cfg_reg == '0)
            eff_cnt = lrp_pkg::COUNT_W'(1);
        else if ({{lrp_pkg::COUNT_W{1'b0}}, cfg_reg} > (lrp_pkg::CFG_W + lrp_pkg::COUNT_W)'(NF))
            eff_cnt = lrp_pkg::COUNT_W'(NF);
        else
            eff_cnt = lrp_pkg::COUNT_W'(cfg_reg);
    end

    // Lookup: lowest matching frame, lowest empty frame, oldest frame.
    always_comb
    begin
        logic                act;
        logic                found_hit;
        logic                found_empty;
        logic                found_lru;
        lrp_pkg::frame_idx_t hit_idx;
        lrp_pkg::frame_idx_t empty_idx;
        lrp_pkg::frame_idx_t lru_idx;
        lrp_pkg::rank_t      lru_rank;
        found_hit   = 1'b0;
        found_empty = 1'b0;
        found_lru   = 1'b0;
        hit_idx     = '0;
        empty_idx   = '0;
        lru_idx     = '0;
        lru_rank    = '0;
        for (int i = 0; i < NF; i++)
        begin
            act = (lrp_pkg::COUNT_W'(i) < eff_cnt);
            if (act && valid_reg[i])
            begin
                if (!found_hit && (tag_reg[i] == page))
                begin
                    found_hit = 1'b1;
                    hit_idx   = lrp_pkg::FRAME_IDX_W'(i);
                end
                if (!found_lru || (rank_reg[i] > lru_rank))
                begin
                    found_lru = 1'b1;
                    lru_rank  = rank_reg[i];
                    lru_idx   = lrp_pkg::FRAME_IDX_W'(i);
                end
            end
            else if (act && !found_empty)
            begin
                found_empty = 1'b1;
                empty_idx   = lrp_pkg::FRAME_IDX_W'(i);
            end
        end

        hit_next        = found_hit;
        evict_next      = 1'b0;
        evict_page_next = '0;
        if (found_hit)
            target_next = hit_idx;
        else if (found_empty)
            target_next = empty_idx;
        else
        begin
            target_next     = lru_idx;
            evict_next      = 1'b1;
            evict_page_next = tag_reg[lru_idx];
        end
    end

    // Age of the touched frame; an empty frame counts as older than all.
    assign old_age = valid_reg[target_reg] ? lrp_pkg::AGE_W'(rank_reg[target_reg])
                                           : lrp_pkg::AGE_W'(NF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= lrp_pkg::CFG_RESET;
        else if (cfg_wr_en)
            cfg_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            faults_reg <= '0;
            for (int i = 0; i < NF; i++)
                rank_reg[i] <= '0;
        end
        else if (cmd.commit)
        begin
            for (int i = 0; i < NF; i++)
            begin
                if (lrp_pkg::FRAME_IDX_W'(i) == target_reg)
                    rank_reg[i] <= '0;
                else if (valid_reg[i] && (lrp_pkg::AGE_W'(rank_reg[i]) < old_age))
                    rank_reg[i] <= rank_reg[i] + lrp_pkg::RANK_W'(1);
            end
            valid_reg[target_reg] <= 1'b1;
            if (!hit_reg && (faults_reg != lrp_pkg::FAULT_MAX))
                faults_reg <= faults_reg + lrp_pkg::FAULT_W'(1);
        end
    end

    // Tags have no reset; only read when the valid bit is set.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            tag_reg[target_reg] <= page_reg;
    end

    // Decision registers double as the result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            page_reg       <= page;
            hit_reg        <= hit_next;
            target_reg     <= target_next;
            evict_reg      <= evict_next;
            evict_page_reg <= evict_page_next;
        end
    end

    assign hit           = hit_reg;
    assign frame_index   = target_reg;
    assign evicted_valid = evict_reg;
    assign evicted_page  = evict_page_reg;
    assign fault_count   = faults_reg;

    a_touch_mru: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> valid_reg[$past(target_reg)] && (rank_reg[$past(target_reg)] == '0))
        else $error("touched frame not valid and most recent");

    a_fault_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !hit_reg) |=>
            (faults_reg == $past(faults_reg) + lrp_pkg::FAULT_W'(1)) ||
            ($past(faults_reg) == lrp_pkg::FAULT_MAX))
        else $error("fault counter did not advance on a miss");

    a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && hit_reg) |=> $stable(faults_reg))
        else $error("fault counter moved on a hit");

    a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && evict_reg |-> !hit_reg && (valid_reg == '1 || eff_cnt != lrp_pkg::COUNT_W'(NF)))
        else $error("eviction with a hit or an empty frame available");

endmodule

[hdl/lru_page_replacement_top.sv]
// Top level of the fully associative LRU page replacement block.
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------------
//  reference | start, busy            | page
//  result    | done (1-cycle strobe)  | hit, frame_index, evicted_valid,
//            |                        | evicted_page, fault_count
//  config    | cfg_wr_en              | cfg_wr_data (frames_in_use)
//
//  A reference transfers at a clock edge with start high and busy low.
//  For each reference, the accept cycle runs the parallel tag
//  compare and victim pick against the stored frames, the update state
//  applies the recency update, tag write and fault count; done pulses in
//  the following cycle, which is also the earliest cycle a new reference
//  transfers, so no new reference is taken while one is in flight.
//  Reset (rst_n low, asynchronous) clears valid bits, ranks, fault count and
//  sets frames_in_use to 4. No clearing pass is needed.
//  Results cannot be stalled; each one is valid in the done cycle and holds until the next reference is accepted.
module lru_page_replacement_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    // reference channel
    input  logic                        start,
    output logic                        busy,
    input  logic [lrp_pkg::PAGE_BITS-1:0] page,
    // result channel
    output logic                        done,
    output logic                        hit,
    output logic [lrp_pkg::FRAME_IDX_W-1:0] frame_index,
    output logic                        evicted_valid,
    output logic [lrp_pkg::PAGE_BITS-1:0] evicted_page,
    output logic [lrp_pkg::FAULT_W-1:0] fault_count,
    // frames_in_use register write
    input  logic                        cfg_wr_en,
    input  logic [lrp_pkg::CFG_W-1:0]   cfg_wr_data
);

    // Command bus from the sequencer to the datapath.
    lrp_pkg::lrp_cmd_t cmd;

    // Two-state sequencer: idle/lookup, then update.
    lrp_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // Frame store, lookup, recency ranks and fault counter.
    lrp_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .page          (page),
        .hit           (hit),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_count   (fault_count)
    );

endmodule
